// ===== sv/ffca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared widths, reset values and the result record of the first-fit
// contiguous block allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int BLOCKS_DEF = 64;

  localparam int LEN_W   = 7;
  localparam int STORE_W = 7;
  localparam int START_W = 6;
  localparam int TOTAL_W = 7;

  localparam logic [STORE_W-1:0] STORE_RESET = 7'd64;

  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] first_block;
    logic [TOTAL_W-1:0] used_total;
    logic [TOTAL_W-1:0] free_total;
  } alloc_result_t;

endpackage

// ===== sv/first_fit_contiguous_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator_unit
// First-fit allocator of contiguous block runs over a used/free bitmap.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid / in_ready     run_length
//  out      output     out_valid / out_ready   granted, first_block,
//                                              used_total, free_total
//  cfg      input      cfg_wr_en               cfg_wr_data (store_blocks)
//
// After reset the bitmap is cleared block by block; in_ready stays low.
// A request scans the bitmap block by block (read, then check); a zero or
// oversize length skips the scan. One request is in work at a time.
// The output register holds a result while out_ready is low; the next request
// may be accepted meanwhile but its result waits for the register to empty.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator_unit #(
  parameter int BLOCKS = ffca_pkg::BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ffca_pkg::STORE_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ffca_pkg::LEN_W-1:0]   run_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         granted,
  output logic [ffca_pkg::START_W-1:0] first_block,
  output logic [ffca_pkg::TOTAL_W-1:0] used_total,
  output logic [ffca_pkg::TOTAL_W-1:0] free_total
);

  localparam int AW = $clog2(BLOCKS);

  logic                    seq_done;
  logic                    load;
  ffca_pkg::alloc_result_t seq_result;
  ffca_pkg::alloc_result_t out_reg;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  assign load = seq_done && (!out_valid || out_ready);

  ffca_seq #(
    .BLOCKS (BLOCKS),
    .AW     (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (in_valid),
    .req_ready   (in_ready),
    .req_len     (run_length),
    .done        (seq_done),
    .take        (load),
    .result      (seq_result),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  ffca_bitmap_ram #(
    .BLOCKS (BLOCKS),
    .AW     (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= seq_result;
    end
  end

  assign granted     = out_reg.granted;
  assign first_block = out_reg.first_block;
  assign used_total  = out_reg.used_total;
  assign free_total  = out_reg.free_total;

endmodule

// ===== sv/ffca_bitmap_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_bitmap_ram
// One-bit-wide used/free bitmap, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffca_bitmap_ram #(
  parameter int BLOCKS = ffca_pkg::BLOCKS_DEF,
  parameter int AW     = $clog2(BLOCKS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ffca_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_seq
// Sequencer: clears the bitmap after reset, scans it one block at a time for
// the first free run, then marks the run used one block per cycle.
// ----------------------------------------------------------------------------
module ffca_seq #(
  parameter int BLOCKS = ffca_pkg::BLOCKS_DEF,
  parameter int AW     = $clog2(BLOCKS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ffca_pkg::STORE_W-1:0] cfg_wr_data,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [ffca_pkg::LEN_W-1:0]   req_len,
  output logic                         done,
  input  logic                         take,
  output ffca_pkg::alloc_result_t      result,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic                         ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic                         ram_rdata
);

  localparam int CW = $clog2(BLOCKS + 1);
  localparam int SW = (CW > ffca_pkg::STORE_W) ? CW : ffca_pkg::STORE_W;
  localparam int LW = ffca_pkg::LEN_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_CHK   = 6'b001000,
    S_MARK  = 6'b010000,
    S_DONE  = 6'b100000
  } seq_state_t;

  seq_state_t state, state_next;

  logic [ffca_pkg::STORE_W-1:0] store_blocks;
  logic [LW-1:0]                len;
  logic [CW-1:0]                pos;
  logic [LW-1:0]                run;
  logic [AW-1:0]                run_start;
  logic [CW-1:0]                used_count;
  logic                         res_granted;
  logic [AW-1:0]                res_start;

  logic [SW-1:0]   store_ext;
  logic [SW-1:0]   size;
  logic [CW-1:0]   pos_inc;
  logic            pos_at_end;
  logic [LW-1:0]   run_inc;
  logic            run_hit;
  logic [AW-1:0]   start_here;
  logic            req_fire;
  logic            len_too_big;
  logic [SW-1:0]   used_ext;
  logic [SW-1:0]   free_cnt;
  logic [AW+ffca_pkg::START_W-1:0] start_wide;
  logic [CW+ffca_pkg::TOTAL_W-1:0] used_wide;

  // effective store size saturates at BLOCKS
  assign store_ext   = SW'(store_blocks);
  assign size        = (store_ext > SW'(BLOCKS)) ? SW'(BLOCKS) : store_ext;
  assign pos_inc     = pos + 1'b1;
  assign pos_at_end  = (SW'(pos_inc) == size);
  assign run_inc     = run + 1'b1;
  assign run_hit     = !ram_rdata && (run_inc == len);
  assign start_here  = (run == '0) ? pos[AW-1:0] : run_start;
  assign req_fire    = req_valid && req_ready;
  assign len_too_big = (SW'(req_len) > size);

  assign req_ready = (state == S_IDLE);
  assign done      = (state == S_DONE);

  assign ram_raddr = pos[AW-1:0];
  assign ram_waddr = pos[AW-1:0];
  assign ram_we    = (state == S_CLEAR) || (state == S_MARK);
  assign ram_wdata = (state == S_MARK);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (pos == CW'(BLOCKS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req_fire) begin
          if (req_len == '0 || len_too_big) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD:    state_next = S_CHK;
      S_CHK: begin
        if (run_hit) begin
          state_next = S_MARK;
        end else if (pos_at_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_MARK:  if (run == LW'(1)) state_next = S_DONE;
      S_DONE:  if (take) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      pos          <= '0;
      used_count   <= '0;
      store_blocks <= ffca_pkg::STORE_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        store_blocks <= cfg_wr_data;
      end
      case (state)
        S_CLEAR: begin
          pos <= (pos == CW'(BLOCKS - 1)) ? '0 : pos_inc;
        end
        S_IDLE: begin
          if (req_fire) begin
            len         <= req_len;
            pos         <= '0;
            run         <= '0;
            res_granted <= (req_len == '0);
            res_start   <= '0;
          end
        end
        S_CHK: begin
          if (ram_rdata) begin
            run <= '0;
            pos <= pos_inc;
          end else if (run_hit) begin
            // run complete: rewind to its start and mark it
            pos         <= CW'(start_here);
            run         <= len;
            res_granted <= 1'b1;
            res_start   <= start_here;
          end else begin
            run       <= run_inc;
            run_start <= start_here;
            pos       <= pos_inc;
          end
        end
        S_MARK: begin
          pos <= pos_inc;
          run <= run - 1'b1;
          if (run == LW'(1)) begin
            used_count <= used_count + CW'(len);
          end
        end
        default: ;
      endcase
    end
  end

  assign used_ext   = SW'(used_count);
  assign free_cnt   = (used_ext >= size) ? '0 : size - used_ext;
  assign start_wide = {{ffca_pkg::START_W{1'b0}}, res_start};
  assign used_wide  = {{ffca_pkg::TOTAL_W{1'b0}}, used_count};

  always_comb begin
    result.granted     = res_granted;
    result.first_block = start_wide[ffca_pkg::START_W-1:0];
    result.used_total  = used_wide[ffca_pkg::TOTAL_W-1:0];
    result.free_total  = free_cnt[ffca_pkg::TOTAL_W-1:0];
  end

endmodule
